// ===== src/cpu_alu_pkg.sv =====
// Package for the 8-bit CPU ALU: operation codes and flag bit positions.
// No dependencies; imported by eight_bit_cpu_alu_with_flags.
`default_nettype none

package cpu_alu_pkg;

  // operation codes, code 31 is unused and leaves everything but the flags at zero
  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_XOR   = 5'd5,
    OP_OR    = 5'd6,
    OP_CP    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_CPL   = 5'd10,
    OP_DAA   = 5'd11,
    OP_RLC   = 5'd12,
    OP_RRC   = 5'd13,
    OP_RL    = 5'd14,
    OP_RR    = 5'd15,
    OP_SLA   = 5'd16,
    OP_SRA   = 5'd17,
    OP_SRL   = 5'd18,
    OP_SWAP  = 5'd19,
    OP_BIT   = 5'd20,
    OP_SET   = 5'd21,
    OP_RES   = 5'd22,
    OP_RLCA  = 5'd23,
    OP_RRCA  = 5'd24,
    OP_RLA   = 5'd25,
    OP_RRA   = 5'd26,
    OP_ADD16 = 5'd27,
    OP_ADDSP = 5'd28,
    OP_INC16 = 5'd29,
    OP_DEC16 = 5'd30
  } alu_op_e;

  // flag bit positions
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  typedef logic [3:0] flags_t;

endpackage

`default_nettype wire

// ===== src/eight_bit_cpu_alu_with_flags.sv =====
// Result: a request accepted by the input register has its result taken with done_o from the result register.
// Throughput: one request per cycle; busy_o is never raised, results cannot be held off.
// Path: input register, one pass of adders and muxes, result register.
// Reset: rst_ni (asynchronous, active low) clears the valid and done bits only.
// Depends on cpu_alu_pkg.
`default_nettype none

module eight_bit_cpu_alu_with_flags (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic [4:0]           op_i,
  input  wire logic [7:0]           acc_i,
  input  wire logic [7:0]           operand_i,
  input  wire logic [2:0]           bit_index_i,
  input  wire cpu_alu_pkg::flags_t  flags_in_i,
  input  wire logic [15:0]          wide_left_i,
  input  wire logic [15:0]          wide_right_i,
  input  wire logic signed [7:0]    offset_i,
  output logic                      done_o,
  output logic [7:0]                result_byte_o,
  output logic [15:0]               result_word_o,
  output cpu_alu_pkg::flags_t       flags_out_o
);
  import cpu_alu_pkg::*;

  logic        valid_q;
  logic [4:0]  op_q;
  logic [7:0]  acc_q;
  logic [7:0]  opnd_q;
  logic [2:0]  bidx_q;
  flags_t      flags_q;
  logic [15:0] wl_q;
  logic [15:0] wr_q;
  logic [7:0]  off_q;

  logic        done_q;
  logic [7:0]  rbyte_q, rbyte_d;
  logic [15:0] rword_q, rword_d;
  flags_t      fout_q, fout_d;

  // never stalls
  assign busy_o = 1'b0;

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      op_q    <= op_i;
      acc_q   <= acc_i;
      opnd_q  <= operand_i;
      bidx_q  <= bit_index_i;
      flags_q <= flags_in_i;
      wl_q    <= wide_left_i;
      wr_q    <= wide_right_i;
      off_q   <= offset_i;
    end
  end

  // shared arithmetic
  logic       cin;
  logic [8:0] add9, sub9;
  logic [4:0] addn, subn;
  logic [7:0] daa_adj;
  logic       daa_cy;
  logic [7:0] src;
  logic [16:0] add17;
  logic [12:0] add13;
  logic [4:0]  sp_n;
  logic [8:0]  sp_b;
  logic [7:0]  bit_mask;

  always_comb begin
    cin  = ((op_q == OP_ADC) || (op_q == OP_SBC)) ? flags_q[FLAG_C] : 1'b0;
    add9 = {1'b0, acc_q} + {1'b0, opnd_q} + {8'd0, cin};
    addn = {1'b0, acc_q[3:0]} + {1'b0, opnd_q[3:0]} + {4'd0, cin};
    sub9 = {1'b0, acc_q} - {1'b0, opnd_q} - {8'd0, cin};
    subn = {1'b0, acc_q[3:0]} - {1'b0, opnd_q[3:0]} - {4'd0, cin};
    // decimal adjust correction
    daa_cy  = flags_q[FLAG_C];
    daa_adj = 8'h00;
    if (flags_q[FLAG_N]) begin
      if (flags_q[FLAG_H]) daa_adj = daa_adj + 8'h06;
      if (flags_q[FLAG_C]) daa_adj = daa_adj + 8'h60;
    end else begin
      if (flags_q[FLAG_C] || (acc_q > 8'h99)) begin
        daa_adj = daa_adj + 8'h60;
        daa_cy  = 1'b1;
      end
      if (flags_q[FLAG_H] || (acc_q[3:0] > 4'h9)) daa_adj = daa_adj + 8'h06;
    end
    src      = ((op_q == OP_RLCA) || (op_q == OP_RRCA) || (op_q == OP_RLA) ||
                (op_q == OP_RRA)) ? acc_q : opnd_q;
    add17    = {1'b0, wl_q} + {1'b0, wr_q};
    add13    = {1'b0, wl_q[11:0]} + {1'b0, wr_q[11:0]};
    sp_n     = {1'b0, wl_q[3:0]} + {1'b0, off_q[3:0]};
    sp_b     = {1'b0, wl_q[7:0]} + {1'b0, off_q};
    bit_mask = 8'd1 << bidx_q;
  end

  // operation select
  always_comb begin
    rbyte_d = 8'h00;
    rword_d = 16'h0000;
    fout_d  = flags_q;
    unique case (op_q)
      OP_ADD, OP_ADC: begin
        rbyte_d = add9[7:0];
        fout_d  = {add9[7:0] == 8'h00, 1'b0, addn[4], add9[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        rbyte_d = (op_q == OP_CP) ? acc_q : sub9[7:0];
        fout_d  = {sub9[7:0] == 8'h00, 1'b1, subn[4], sub9[8]};
      end
      OP_AND: begin
        rbyte_d = acc_q & opnd_q;
        fout_d  = {(acc_q & opnd_q) == 8'h00, 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        rbyte_d = acc_q ^ opnd_q;
        fout_d  = {(acc_q ^ opnd_q) == 8'h00, 3'b000};
      end
      OP_OR: begin
        rbyte_d = acc_q | opnd_q;
        fout_d  = {(acc_q | opnd_q) == 8'h00, 3'b000};
      end
      OP_INC: begin
        rbyte_d = opnd_q + 8'd1;
        fout_d  = {opnd_q == 8'hFF, 1'b0, opnd_q[3:0] == 4'hF, flags_q[FLAG_C]};
      end
      OP_DEC: begin
        rbyte_d = opnd_q - 8'd1;
        fout_d  = {opnd_q == 8'h01, 1'b1, opnd_q[3:0] == 4'h0, flags_q[FLAG_C]};
      end
      OP_CPL: begin
        rbyte_d = ~acc_q;
        fout_d  = {flags_q[FLAG_Z], 1'b1, 1'b1, flags_q[FLAG_C]};
      end
      OP_DAA: begin
        rbyte_d = flags_q[FLAG_N] ? (acc_q - daa_adj) : (acc_q + daa_adj);
        fout_d  = {rbyte_d == 8'h00, flags_q[FLAG_N], 1'b0, daa_cy};
      end
      OP_RLC, OP_RLCA: begin
        rbyte_d = {src[6:0], src[7]};
        fout_d  = {(op_q == OP_RLC) && (src == 8'h00), 2'b00, src[7]};
      end
      OP_RRC, OP_RRCA: begin
        rbyte_d = {src[0], src[7:1]};
        fout_d  = {(op_q == OP_RRC) && (src == 8'h00), 2'b00, src[0]};
      end
      OP_RL, OP_RLA: begin
        rbyte_d = {src[6:0], flags_q[FLAG_C]};
        fout_d  = {(op_q == OP_RL) && (rbyte_d == 8'h00), 2'b00, src[7]};
      end
      OP_RR, OP_RRA: begin
        rbyte_d = {flags_q[FLAG_C], src[7:1]};
        fout_d  = {(op_q == OP_RR) && (rbyte_d == 8'h00), 2'b00, src[0]};
      end
      OP_SLA: begin
        rbyte_d = {src[6:0], 1'b0};
        fout_d  = {rbyte_d == 8'h00, 2'b00, src[7]};
      end
      OP_SRA: begin
        rbyte_d = {src[7], src[7:1]};
        fout_d  = {rbyte_d == 8'h00, 2'b00, src[0]};
      end
      OP_SRL: begin
        rbyte_d = {1'b0, src[7:1]};
        fout_d  = {rbyte_d == 8'h00, 2'b00, src[0]};
      end
      OP_SWAP: begin
        rbyte_d = {opnd_q[3:0], opnd_q[7:4]};
        fout_d  = {opnd_q == 8'h00, 3'b000};
      end
      OP_BIT: begin
        rbyte_d = opnd_q;
        fout_d  = {(opnd_q & bit_mask) == 8'h00, 1'b0, 1'b1, flags_q[FLAG_C]};
      end
      OP_SET: rbyte_d = opnd_q | bit_mask;
      OP_RES: rbyte_d = opnd_q & ~bit_mask;
      OP_ADD16: begin
        rword_d = add17[15:0];
        fout_d  = {flags_q[FLAG_Z], 1'b0, add13[12], add17[16]};
      end
      OP_ADDSP: begin
        rword_d = wl_q + {{8{off_q[7]}}, off_q};
        fout_d  = {2'b00, sp_n[4], sp_b[8]};
      end
      OP_INC16: rword_d = wl_q + 16'd1;
      OP_DEC16: rword_d = wl_q - 16'd1;
      default: begin
        rbyte_d = 8'h00;
      end
    endcase
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q) begin
      rbyte_q <= rbyte_d;
      rword_q <= rword_d;
      fout_q  <= fout_d;
    end
  end

  assign done_o        = done_q;
  assign result_byte_o = rbyte_q;
  assign result_word_o = rword_q;
  assign flags_out_o   = fout_q;

`ifndef SYNTHESIS
  a_req_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("accepted request produced no result");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(valid_q))
    else $error("result strobe without a request");

  a_byte_or_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_word_o != 16'h0000)) |-> (result_byte_o == 8'h00))
    else $error("byte and word results both nonzero");

  a_cp_keeps_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && (op_q == OP_CP)) |-> (rbyte_d == acc_q && fout_d[FLAG_N]))
    else $error("compare altered the accumulator");
`endif

endmodule

`default_nettype wire
